// ===== src/ehsd_pkg.sv =====
package ehsd_pkg;

   localparam int IDX_W  = 10;
   localparam int WORD_W = 16;
   localparam int STAT_W = 2;

   localparam int MAX_WORDS = 1024;
   localparam logic [IDX_W-1:0] FIRST_PROTECTED_RESET = 10'd16;
   localparam logic [IDX_W:0] PROTECTED_END = 11'd832;
   localparam logic [WORD_W-1:0] DATA_MASK = 16'h07FF;

   localparam logic [WORD_W-1:0] CHK0_MASK = 16'h0D5B;
   localparam logic [WORD_W-1:0] CHK1_MASK = 16'h166D;
   localparam logic [WORD_W-1:0] CHK2_MASK = 16'h278E;
   localparam logic [WORD_W-1:0] CHK3_MASK = 16'h47F0;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type STAT_OK            = 2'd0;
   localparam status_type STAT_CORRECTED     = 2'd1;
   localparam status_type STAT_UNCORRECTABLE = 2'd2;

   // bit position to flip for each syndrome value
   function automatic logic [3:0] flip_pos(input logic [3:0] syn);
      logic [3:0] pos;
      case (syn)
         4'd0:    pos = 4'd15;
         4'd1:    pos = 4'd11;
         4'd2:    pos = 4'd12;
         4'd3:    pos = 4'd0;
         4'd4:    pos = 4'd13;
         4'd5:    pos = 4'd1;
         4'd6:    pos = 4'd2;
         4'd7:    pos = 4'd3;
         4'd8:    pos = 4'd14;
         4'd9:    pos = 4'd4;
         4'd10:   pos = 4'd5;
         4'd11:   pos = 4'd6;
         4'd12:   pos = 4'd7;
         4'd13:   pos = 4'd8;
         4'd14:   pos = 4'd9;
         4'd15:   pos = 4'd10;
         default: pos = 4'd15;
      endcase
      return pos;
   endfunction

endpackage

// ===== src/eeprom_hamming_secded_decoder_unit.sv =====
// secded (16,11) checker for a stream of calibration memory words
//
// req channel: tdata[9:0] word index, tdata[25:10] raw word, tlast marks the
// final word of a dump. rsp channel: tdata the output word, tuser[1:0] word
// status, tuser[3:2] sticky run status, tlast repeats the last-word mark.
// csr_we/csr_wdata write the first protected index (words below it pass).
//
// every word goes through an input register and a result register; a result
// shows on rsp once it is in the result register. one word per cycle is
// sustained while rsp_tready stays high; the limit is the single
// parity/correct stage between the two registers. if rsp_tready stays low
// both registers fill and req_tready drops as soon as both are full;
// nothing is lost or dropped.
//
// reset empties both registers, clears the run status and sets the first
// protected index to 16. the run status clears after the word marked last.
module eeprom_hamming_secded_decoder_unit
   import ehsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [9:0] word_index, [25:10] word_data
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_data
   output logic [3:0]  rsp_tuser,   // [1:0] word_status, [3:2] run_status
   output logic        rsp_tlast,   // run_done
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata
);

   logic [IDX_W-1:0]  first_idx_ff;
   logic              in_valid_ff;
   logic [IDX_W-1:0]  in_idx_ff;
   logic [WORD_W-1:0] in_word_ff;
   logic              in_last_ff;
   logic              out_valid_ff;
   logic [WORD_W-1:0] out_data_ff;
   status_type        out_wstat_ff;
   status_type        out_rstat_ff;
   logic              out_last_ff;
   status_type        sticky_ff;

   logic              out_load;
   logic              in_load;
   logic              protect;
   logic [3:0]        syn;
   logic              overall;
   logic [WORD_W-1:0] fixed_word;
   logic [WORD_W-1:0] out_data_in;
   status_type        wstat_in;
   status_type        rstat_in;
   status_type        sticky_in;

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   always_comb begin
      protect = ({1'b0, in_idx_ff} >= {1'b0, first_idx_ff})
             && ({1'b0, in_idx_ff} < PROTECTED_END)
             && ({7'd0, in_idx_ff} < 17'(MAX_WORDS));
      syn[0]  = ^(in_word_ff & CHK0_MASK);
      syn[1]  = ^(in_word_ff & CHK1_MASK);
      syn[2]  = ^(in_word_ff & CHK2_MASK);
      syn[3]  = ^(in_word_ff & CHK3_MASK);
      overall = ^in_word_ff;
      fixed_word = in_word_ff;
      wstat_in   = STAT_OK;
      if (overall) begin
         fixed_word = in_word_ff ^ (WORD_W'(1) << flip_pos(syn));
         wstat_in   = STAT_CORRECTED;
      end else if (syn != 4'd0) begin
         wstat_in = STAT_UNCORRECTABLE;
      end
      rstat_in    = sticky_ff;
      out_data_in = in_word_ff;
      if (protect) begin
         out_data_in = fixed_word & DATA_MASK;
         if (wstat_in == STAT_UNCORRECTABLE) begin
            rstat_in = STAT_UNCORRECTABLE;
         end else if (wstat_in == STAT_CORRECTED && sticky_ff == STAT_OK) begin
            rstat_in = STAT_CORRECTED;
         end
      end else begin
         wstat_in = STAT_OK;
      end
      sticky_in = in_last_ff ? STAT_OK : rstat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_idx_ff <= FIRST_PROTECTED_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sticky_ff    <= STAT_OK;
      end else begin
         if (csr_we) begin
            first_idx_ff <= csr_wdata;
         end
         if (in_load) begin
            in_valid_ff <= 1'b1;
         end else if (out_load) begin
            in_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            sticky_ff    <= sticky_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_idx_ff  <= req_tdata[9:0];
         in_word_ff <= req_tdata[25:10];
         in_last_ff <= req_tlast;
      end
      if (out_load) begin
         out_data_ff  <= out_data_in;
         out_wstat_ff <= wstat_in;
         out_rstat_ff <= rstat_in;
         out_last_ff  <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_rstat_ff, out_wstat_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== test/tb_eeprom_hamming_secded_decoder_unit.sv =====
module tb_eeprom_hamming_secded_decoder_unit
   import ehsd_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [WORD_W-1:0] data;
      status_type        word_stat;
      status_type        run_stat;
      logic              done;
   } decoded_word_type;

   // predicts the decoder output and keeps the words still in flight
   class secded_tracker;
      logic [IDX_W-1:0] first_index;
      status_type       run_state;
      decoded_word_type pending_words[$];
      int               errors;

      function new();
         first_index = FIRST_PROTECTED_RESET;
         run_state = STAT_OK;
         errors = 0;
      endfunction

      function void set_first(input logic [IDX_W-1:0] v);
         first_index = v;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void take_word(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] raw,
                              input logic last);
         decoded_word_type r;
         logic [WORD_W-1:0] w;
         logic [3:0] syn;
         logic [3:0] column;
         w = raw;
         r.data = raw;
         r.word_stat = STAT_OK;
         if (idx >= first_index && idx < PROTECTED_END) begin
            syn = {^(w & CHK3_MASK), ^(w & CHK2_MASK), ^(w & CHK1_MASK), ^(w & CHK0_MASK)};
            if (^w) begin
               // the bit whose check column equals the syndrome is the bad one
               for (int b = 0; b < WORD_W; b++) begin
                  column = {CHK3_MASK[b], CHK2_MASK[b], CHK1_MASK[b], CHK0_MASK[b]};
                  if (column == syn) w[b] = ~w[b];
               end
               r.word_stat = STAT_CORRECTED;
            end else if (syn != 4'd0) begin
               r.word_stat = STAT_UNCORRECTABLE;
            end
            r.data = w & DATA_MASK;
            if (r.word_stat == STAT_UNCORRECTABLE)
               run_state = STAT_UNCORRECTABLE;
            else if (r.word_stat == STAT_CORRECTED && run_state == STAT_OK)
               run_state = STAT_CORRECTED;
         end
         r.run_stat = run_state;
         r.done = last;
         if (last) run_state = STAT_OK;
         pending_words.push_back(r);
      endfunction

      function void check_word(input logic [WORD_W-1:0] data, input logic [3:0] user,
                               input logic last);
         decoded_word_type e;
         if (pending_words.size() == 0) begin
            $display("%0t: word out with none expected, data %h", $time, data);
            errors++;
            return;
         end
         e = pending_words.pop_front();
         if (data !== e.data) begin
            $display("%0t: out_data expected %h actual %h", $time, e.data, data);
            errors++;
         end
         if (user[1:0] !== e.word_stat) begin
            $display("%0t: word_status expected %0d actual %0d", $time, e.word_stat, user[1:0]);
            errors++;
         end
         if (user[3:2] !== e.run_stat) begin
            $display("%0t: run_status expected %0d actual %0d", $time, e.run_stat, user[3:2]);
            errors++;
         end
         if (last !== e.done) begin
            $display("%0t: run_done expected %0d actual %0d", $time, e.done, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [9:0]  csr_wdata = '0;

   logic req_idle_on = 1'b1;
   logic rsp_idle_on = 1'b1;
   int   stall_left = 0;
   int   cycle_count = 0;

   secded_tracker tracker = new();

   eeprom_hamming_secded_decoder_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.take_word(req_tdata[9:0], req_tdata[25:10], req_tlast);
         if (rsp_tvalid && rsp_tready)
            tracker.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // receiver stalls in bursts of random length while rsp_idle_on is set
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // check bits 11..14 clear the four syndromes, bit 15 makes overall parity even
   function automatic logic [15:0] encode_codeword(input logic [10:0] d);
      logic [15:0] w;
      w = {5'd0, d};
      w[11] = ^(w & CHK0_MASK);
      w[12] = ^(w & CHK1_MASK);
      w[13] = ^(w & CHK2_MASK);
      w[14] = ^(w & CHK3_MASK);
      w[15] = ^w;
      return w;
   endfunction

   function automatic logic [15:0] make_word();
      logic [15:0] w;
      int pick;
      int b1;
      int b2;
      pick = $urandom_range(0, 99);
      w = encode_codeword(11'($urandom));
      b1 = $urandom_range(0, 15);
      b2 = (b1 + $urandom_range(1, 15)) % 16;
      if (pick < 30) begin
         w = w;
      end else if (pick < 60) begin
         w = w ^ (16'd1 << b1);
      end else if (pick < 80) begin
         w = w ^ (16'd1 << b1) ^ (16'd1 << b2);
      end else begin
         w = 16'($urandom);
      end
      return w;
   endfunction

   task automatic send_word(input logic [9:0] idx, input logic [15:0] raw, input logic last);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, raw, idx};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_words();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_first_index(input logic [9:0] v);
      drain_words();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_first(v);
   endtask

   task automatic run_random(input int n_words, input bit quiet);
      int left;
      int run_len;
      int pick;
      logic [9:0] idx;
      logic last;
      left = n_words;
      while (left > 0) begin
         run_len = $urandom_range(1, 40);
         if (run_len > left) run_len = left;
         req_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
         rsp_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
         // start runs near the edges of the checked range now and then
         pick = $urandom_range(0, 7);
         if (pick < 2)
            idx = tracker.first_index - 10'($urandom_range(0, 8));
         else if (pick == 2)
            idx = 10'($urandom_range(820, 831));
         else
            idx = 10'($urandom_range(0, 1023));
         for (int k = 0; k < run_len; k++) begin
            if (k == run_len - 1)
               last = ($urandom_range(0, 7) != 0);
            else
               last = ($urandom_range(0, 31) == 0);
            send_word(idx, make_word(), last);
            if ($urandom_range(0, 15) == 0)
               idx = 10'($urandom_range(0, 1023));
            else
               idx = idx + 10'd1;
         end
         left -= run_len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset value of the first checked index is in force here
      send_word(10'd0, 16'hFFFF, 1'b0);
      send_word(10'd15, 16'h0000, 1'b0);
      send_word(10'd16, encode_codeword(11'h7FF), 1'b0);
      send_word(10'd17, encode_codeword(11'h000), 1'b0);
      for (int b = 0; b < 16; b++)
         send_word(10'(20 + b), encode_codeword(11'($urandom)) ^ (16'd1 << b), 1'b0);
      send_word(10'd40, encode_codeword(11'h2AA) ^ 16'h0003, 1'b0);
      // a later correction does not lower an uncorrectable run
      send_word(10'd831, encode_codeword(11'h555) ^ 16'h0400, 1'b0);
      send_word(10'd832, 16'hFFFF, 1'b0);
      send_word(10'd1023, encode_codeword(11'h123) ^ 16'h8000, 1'b1);

      write_first_index(10'd0);
      run_random(150, 1'b0);
      write_first_index(10'd1023);
      run_random(100, 1'b0);
      write_first_index(10'd831);
      run_random(120, 1'b0);
      write_first_index(10'd832);
      run_random(100, 1'b0);
      write_first_index(10'd1);
      run_random(150, 1'b0);
      write_first_index(10'($urandom_range(0, 1023)));
      run_random(150, 1'b0);
      write_first_index(10'd16);
      run_random(160, 1'b1);

      drain_words();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/ehsd_pkg.sv
src/eeprom_hamming_secded_decoder_unit.sv
test/tb_eeprom_hamming_secded_decoder_unit.sv
